// File: rtl/sorted_priority_queue_unit_macros.svh
// Assertion macros for the sorted priority queue unit
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Clocked check, off while reset is held
`define SPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sorted priority queue check failed");

// Clocked check with its own message
`define SPQ_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// Package of the sorted priority queue unit: sizes, codes, states and entry type
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_REM = 2'd2,
        OP_EXP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_FIND,
        S_SHIFT,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] tm;
        logic [15:0] prio;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue unit
//
// A bounded queue of up to spq_pkg::DEPTH entries (id, check-in time,
// priority), held in one synchronous memory in ascending priority order;
// equal priorities keep their arrival order.
// Command channel: a word is taken at a rising edge with start high and
// busy low. Results leave on the o_ ports, each for one cycle with o_strobe
// high; o_last marks the final word of a command. The receiver cannot hold
// results off, so none are buffered beyond the output register.
// Work per command, with n entries held and one memory read per cycle:
//   enqueue        : walks down from the tail, moving each entry with a
//                    larger priority up one place; at once if full
//                    or empty
//   dequeue/remove : scans from the head to the entry, then shifts every later entry down; at once if empty
//   collect expired: scans all n entries, plus a flush when the last expires
// A command answered at once (full or empty) leaves the unit free for the
// next cycle; otherwise the next word is taken in the cycle of the final
// result. Expired ids leave during the scan, each once the next is found.
// i_cfg_we writes the wait limit; write it only while the unit is idle.
// Reset (synchronous, active low) empties the queue and clears the limit;
// the memory contents are not cleared, only the fill count.
`default_nettype none

`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_op,
    input  wire logic [15:0]               i_item_id,
    input  wire logic [15:0]               i_check_in_time,
    input  wire logic signed [15:0]        i_prio,
    input  wire logic [15:0]               i_now_time,
    input  wire logic                      i_cfg_we,
    input  wire logic [15:0]               i_cfg_wdata,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic [15:0]                    o_out_id,
    output logic [15:0]                    o_out_check_in,
    output logic signed [15:0]             o_out_prio,
    output logic [spq_pkg::OCC_W-1:0]      o_occupancy,
    output logic                           o_last
);

    localparam int IW = spq_pkg::IDX_W;
    localparam int CW = spq_pkg::CNT_W;

    // Entry memory, one write and one registered read per cycle
    spq_pkg::t_entry r_mem [spq_pkg::DEPTH];
    spq_pkg::t_entry r_rdata;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    logic [IW-1:0]   mem_ra;
    spq_pkg::t_entry mem_wd;

    spq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_idx, n_idx;
    logic [15:0]     r_limit;
    spq_pkg::t_op    r_op, n_op;
    spq_pkg::t_entry r_new, n_new;
    logic [15:0]     r_now, n_now;
    spq_pkg::t_entry r_hold, n_hold;
    logic            r_pend, n_pend;
    logic [15:0]     r_pend_id, n_pend_id;

    logic            r_strobe, n_strobe;
    spq_pkg::t_status r_status, n_status;
    spq_pkg::t_entry r_res, n_res;
    logic            r_last, n_last;

    logic [CW-1:0]   idx_inc;
    logic [CW-1:0]   idx_dec;
    logic            more;
    logic            accept;
    logic signed [16:0] wait_diff;
    logic            expired;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    assign accept  = start && (r_state == spq_pkg::S_IDLE);
    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;
    assign more    = (idx_inc < r_fill);
    // wait is a true difference of two unsigned times, never wrapped
    assign wait_diff = $signed({1'b0, r_now}) - $signed({1'b0, r_rdata.tm});
    assign expired   = (wait_diff > $signed({1'b0, r_limit}));

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_op      = r_op;
        n_new     = r_new;
        n_now     = r_now;
        n_hold    = r_hold;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_strobe  = 1'b0;
        n_status  = spq_pkg::STS_OK;
        n_res     = '0;
        n_last    = 1'b1;
        mem_we    = 1'b0;
        mem_wa    = r_idx[IW-1:0];
        mem_wd    = r_new;
        mem_ra    = r_idx[IW-1:0];

        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (accept) begin
                    n_op      = spq_pkg::t_op'(i_op);
                    n_new.id  = i_item_id;
                    n_new.tm  = i_check_in_time;
                    n_new.prio = i_prio;
                    n_now     = i_now_time;
                    n_pend    = 1'b0;
                    unique case (spq_pkg::t_op'(i_op))
                        spq_pkg::OP_ENQ: begin
                            if (r_fill == CW'(spq_pkg::DEPTH)) begin
                                n_strobe = 1'b1;
                                n_status = spq_pkg::STS_FULL;
                            end else if (r_fill == '0) begin
                                // empty: place at the head at once
                                mem_we   = 1'b1;
                                mem_wa   = '0;
                                mem_wd.id   = i_item_id;
                                mem_wd.tm   = i_check_in_time;
                                mem_wd.prio = i_prio;
                                n_fill   = r_fill + 1'b1;
                                n_strobe = 1'b1;
                            end else begin
                                // walk down from the tail
                                n_idx   = r_fill - 1'b1;
                                mem_ra  = n_idx[IW-1:0];
                                n_state = spq_pkg::S_INS;
                            end
                        end
                        spq_pkg::OP_DEQ, spq_pkg::OP_REM: begin
                            if (r_fill == '0) begin
                                n_strobe = 1'b1;
                                n_status = spq_pkg::STS_MISS;
                            end else begin
                                n_idx   = '0;
                                mem_ra  = '0;
                                n_state = spq_pkg::S_FIND;
                            end
                        end
                        default: begin
                            if (r_fill == '0) begin
                                n_strobe = 1'b1;
                                n_status = spq_pkg::STS_MISS;
                            end else begin
                                n_idx   = '0;
                                mem_ra  = '0;
                                n_state = spq_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end

            spq_pkg::S_INS: begin
                mem_we = 1'b1;
                mem_wa = idx_inc[IW-1:0];
                if ($signed(r_rdata.prio) > $signed(r_new.prio)) begin
                    // move the larger entry up one place
                    mem_wd = r_rdata;
                    if (r_idx == '0) begin
                        n_state = spq_pkg::S_PUT;
                    end else begin
                        n_idx  = idx_dec;
                        mem_ra = idx_dec[IW-1:0];
                    end
                end else begin
                    mem_wd   = r_new;
                    n_fill   = r_fill + 1'b1;
                    n_strobe = 1'b1;
                    n_state  = spq_pkg::S_IDLE;
                end
            end

            spq_pkg::S_PUT: begin
                mem_we   = 1'b1;
                mem_wa   = r_idx[IW-1:0];
                mem_wd   = r_new;
                n_fill   = r_fill + 1'b1;
                n_strobe = 1'b1;
                n_state  = spq_pkg::S_IDLE;
            end

            spq_pkg::S_FIND: begin
                if ((r_op == spq_pkg::OP_DEQ) || (r_rdata.id == r_new.id)) begin
                    n_hold = r_rdata;
                    if (more) begin
                        n_idx   = idx_inc;
                        mem_ra  = idx_inc[IW-1:0];
                        n_state = spq_pkg::S_SHIFT;
                    end else begin
                        n_fill   = r_fill - 1'b1;
                        n_strobe = 1'b1;
                        n_res    = r_rdata;
                        n_state  = spq_pkg::S_IDLE;
                    end
                end else if (more) begin
                    n_idx  = idx_inc;
                    mem_ra = idx_inc[IW-1:0];
                end else begin
                    n_strobe = 1'b1;
                    n_status = spq_pkg::STS_MISS;
                    n_state  = spq_pkg::S_IDLE;
                end
            end

            spq_pkg::S_SHIFT: begin
                // close the gap: move each later entry down one place
                mem_we = 1'b1;
                mem_wa = idx_dec[IW-1:0];
                mem_wd = r_rdata;
                if (more) begin
                    n_idx  = idx_inc;
                    mem_ra = idx_inc[IW-1:0];
                end else begin
                    n_fill   = r_fill - 1'b1;
                    n_strobe = 1'b1;
                    n_res    = r_hold;
                    n_state  = spq_pkg::S_IDLE;
                end
            end

            spq_pkg::S_SCAN: begin
                // one expired id is held back so the final one can carry last
                if (expired) begin
                    n_pend    = 1'b1;
                    n_pend_id = r_rdata.id;
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_res.id = r_pend_id;
                        n_last   = 1'b0;
                    end
                end
                if (more) begin
                    n_idx  = idx_inc;
                    mem_ra = idx_inc[IW-1:0];
                end else if (expired) begin
                    n_state = spq_pkg::S_FLUSH;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = spq_pkg::S_IDLE;
                    if (r_pend) begin
                        n_res.id = r_pend_id;
                    end else begin
                        n_status = spq_pkg::STS_MISS;
                    end
                end
            end

            spq_pkg::S_FLUSH: begin
                n_strobe = 1'b1;
                n_res.id = r_pend_id;
                n_state  = spq_pkg::S_IDLE;
            end

            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spq_pkg::S_IDLE;
            r_fill   <= '0;
            r_limit  <= '0;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_op      <= n_op;
        r_new     <= n_new;
        r_now     <= n_now;
        r_hold    <= n_hold;
        r_pend_id <= n_pend_id;
        r_status  <= n_status;
        r_res     <= n_res;
        r_last    <= n_last;
    end

    assign busy           = (r_state != spq_pkg::S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_id       = r_res.id;
    assign o_out_check_in = r_res.tm;
    assign o_out_prio     = $signed(r_res.prio);
    assign o_occupancy    = spq_pkg::OCC_W'(r_fill);
    assign o_last         = r_last;

    `SPQ_ASSERT(a_fill_bound, (r_fill <= CW'(spq_pkg::DEPTH)))
    `SPQ_ASSERT_MSG(a_full_only_when_full,
        (r_strobe && (r_status == spq_pkg::STS_FULL)) |-> (r_fill == CW'(spq_pkg::DEPTH)),
        "full status with room left")
    `SPQ_ASSERT_MSG(a_shift_in_range, (r_state == spq_pkg::S_SHIFT) |-> (r_idx < r_fill),
        "shift beyond the filled entries")

endmodule

`default_nettype wire

// File: verif/tb_sorted_priority_queue_unit.sv
// Testbench of the sorted priority queue unit: directed and random commands against a predictor
`timescale 1ns / 100ps
`default_nettype none

module tb_sorted_priority_queue_unit;

    // Limit on cycles with nothing accepted; the longest command walks
    // the whole memory after the longest random gap
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 3 * spq_pkg::DEPTH + 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [15:0] tm;
        logic [15:0] prio;
        logic [4:0]  occ;
        logic        last;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_op = '0;
    logic [15:0]       i_item_id = '0;
    logic [15:0]       i_check_in_time = '0;
    logic signed [15:0] i_prio = '0;
    logic [15:0]       i_now_time = '0;
    logic              i_cfg_we = 1'b0;
    logic [15:0]       i_cfg_wdata = '0;
    logic              o_strobe;
    logic [1:0]        o_status;
    logic [15:0]       o_out_id;
    logic [15:0]       o_out_check_in;
    logic signed [15:0] o_out_prio;
    logic [spq_pkg::OCC_W-1:0] o_occupancy;
    logic              o_last;

    sorted_priority_queue_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_item_id(i_item_id), .i_check_in_time(i_check_in_time),
        .i_prio(i_prio), .i_now_time(i_now_time),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe), .o_status(o_status), .o_out_id(o_out_id),
        .o_out_check_in(o_out_check_in), .o_out_prio(o_out_prio),
        .o_occupancy(o_occupancy), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the queue, front at index 0
    spq_pkg::t_entry shadow_q[$];
    logic [15:0] shadow_limit;
    t_result     pending_words[$];

    int errors = 0;
    int words_seen = 0;
    int cmds_sent = 0;
    int expired_seen = 0;
    int full_seen = 0;
    int idle_count = 0;
    bit timed_out = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] error: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic t_result mk_word(logic [1:0] st, logic [15:0] id,
                                        logic [15:0] tm, logic [15:0] pr, logic lst);
        t_result r;
        r.status = st; r.id = id; r.tm = tm; r.prio = pr;
        r.occ = 5'(shadow_q.size()); r.last = lst;
        return r;
    endfunction

    // Work out the words one command produces and update the shadow queue
    task automatic predict_queue(input spq_pkg::t_op op, input logic [15:0] id,
                                 input logic [15:0] tm, input logic [15:0] pr,
                                 input logic [15:0] now);
        int pos;
        int n;
        int wait_v;
        spq_pkg::t_entry e;
        case (op)
            spq_pkg::OP_ENQ: begin
                if (shadow_q.size() >= spq_pkg::DEPTH) begin
                    pending_words.push_back(mk_word(spq_pkg::STS_FULL, '0, '0, '0, 1'b1));
                    full_seen++;
                end else begin
                    pos = 0;
                    while (pos < shadow_q.size() &&
                           $signed(shadow_q[pos].prio) <= $signed(pr)) pos++;
                    e.id = id; e.tm = tm; e.prio = pr;
                    shadow_q.insert(pos, e);
                    pending_words.push_back(mk_word(spq_pkg::STS_OK, '0, '0, '0, 1'b1));
                end
            end
            spq_pkg::OP_DEQ, spq_pkg::OP_REM: begin
                pos = 0;
                if (op == spq_pkg::OP_REM)
                    while (pos < shadow_q.size() && shadow_q[pos].id != id) pos++;
                if (pos >= shadow_q.size()) begin
                    pending_words.push_back(mk_word(spq_pkg::STS_MISS, '0, '0, '0, 1'b1));
                end else begin
                    e = shadow_q[pos];
                    shadow_q.delete(pos);
                    pending_words.push_back(mk_word(spq_pkg::STS_OK, e.id, e.tm, e.prio,
                                                    1'b1));
                end
            end
            default: begin
                n = 0;
                foreach (shadow_q[i]) begin
                    wait_v = int'(now) - int'(shadow_q[i].tm);
                    if (wait_v > int'(shadow_limit)) begin
                        pending_words.push_back(mk_word(spq_pkg::STS_OK, shadow_q[i].id,
                                                        '0, '0, 1'b0));
                        n++;
                    end
                end
                if (n == 0)
                    pending_words.push_back(mk_word(spq_pkg::STS_MISS, '0, '0, '0, 1'b1));
                else pending_words[$].last = 1'b1;
                expired_seen += n;
            end
        endcase
    endtask

    // Send one command word after a random gap; hold start until accepted.
    // start stays high after the accepting edge; a later gap or caller drops it.
    task automatic send_cmd(input spq_pkg::t_op op, input logic [15:0] id,
                            input logic [15:0] tm, input logic [15:0] pr,
                            input logic [15:0] now);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op; i_item_id <= id; i_check_in_time <= tm;
        i_prio <= pr; i_now_time <= now;
        do @(posedge i_clk); while (busy);
        predict_queue(op, id, tm, pr, now);
        cmds_sent++;
    endtask

    // Drain outstanding words, let the unit settle, then write the limit
    task automatic write_limit(input logic [15:0] lim);
        start <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_limit = lim;
    endtask

    // Check each strobed word against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word, id", 32'(o_out_id), '0);
            end else begin
                want = pending_words.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_out_id != want.id)
                    report_mismatch("out_id", 32'(o_out_id), 32'(want.id));
                if (o_out_check_in != want.tm)
                    report_mismatch("out_check_in", 32'(o_out_check_in), 32'(want.tm));
                if (o_out_prio != want.prio)
                    report_mismatch("out_prio", 32'(o_out_prio), 32'(want.prio));
                if (o_occupancy != want.occ)
                    report_mismatch("occupancy", 32'(o_occupancy), 32'(want.occ));
                if (o_last != want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // Watchdog: count cycles with neither a command taken nor a word out
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] pick_prio();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Extremes of each field, empty and full queue, misses and ties
    task automatic test_directed();
        write_limit(16'd0);
        send_cmd(spq_pkg::OP_DEQ, '0, '0, '0, '0);
        send_cmd(spq_pkg::OP_REM, 16'h1234, '0, '0, '0);
        send_cmd(spq_pkg::OP_EXP, '0, '0, '0, 16'hffff);
        send_cmd(spq_pkg::OP_ENQ, 16'hffff, 16'hffff, 16'h7fff, '0);
        send_cmd(spq_pkg::OP_ENQ, 16'h0000, 16'h0000, 16'h8000, '0);
        send_cmd(spq_pkg::OP_ENQ, 16'h00aa, 16'h0010, 16'h0005, '0);
        send_cmd(spq_pkg::OP_ENQ, 16'h00bb, 16'h0020, 16'h0005, '0);
        // wait 0 with limit 0 is not expired; negative wait is never expired
        send_cmd(spq_pkg::OP_EXP, '0, '0, '0, 16'h0010);
        send_cmd(spq_pkg::OP_EXP, '0, '0, '0, 16'hffff);
        send_cmd(spq_pkg::OP_REM, 16'h00bb, '0, '0, '0);
        send_cmd(spq_pkg::OP_REM, 16'h5555, '0, '0, '0);
        for (int i = 0; i < 14; i++)
            send_cmd(spq_pkg::OP_ENQ, 16'(i), 16'(i), 16'(3 - i), '0);
        send_cmd(spq_pkg::OP_ENQ, 16'hdead, '0, '0, '0);
        send_cmd(spq_pkg::OP_EXP, '0, '0, '0, 16'h7fff);
        repeat (8) send_cmd(spq_pkg::OP_DEQ, '0, '0, '0, '0);
    endtask

    // Mostly well-formed traffic with random content across several limits
    task automatic test_random(input int count);
        int roll;
        logic [15:0] id;
        for (int k = 0; k < count; k++) begin
            if (k % 45 == 0) begin
                case (k / 45)
                    0: write_limit(16'hffff);
                    1: write_limit(16'($urandom_range(0, 64)));
                    2: write_limit(16'd0);
                    default: write_limit(16'($urandom));
                endcase
            end
            roll = $urandom_range(0, 9);
            if (roll < 5 && shadow_q.size() < spq_pkg::DEPTH || roll == 9) begin
                send_cmd(spq_pkg::OP_ENQ, 16'($urandom), 16'($urandom), pick_prio(), '0);
            end else if (roll < 7) begin
                send_cmd(spq_pkg::OP_DEQ, 16'($urandom), '0, '0, '0);
            end else if (roll < 8) begin
                id = (shadow_q.size() > 0 && $urandom_range(0, 3) != 0)
                    ? shadow_q[$urandom_range(0, shadow_q.size() - 1)].id : 16'($urandom);
                send_cmd(spq_pkg::OP_REM, id, '0, '0, '0);
            end else begin
                send_cmd(spq_pkg::OP_EXP, '0, '0, '0, 16'($urandom));
            end
        end
    endtask

    initial begin
        shadow_limit = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(150);
        start <= 1'b0;
        fork
            wait (pending_words.size() == 0);
            begin
                repeat (100000) @(posedge i_clk);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out) begin
            $display("expected words still outstanding: %0d", pending_words.size());
            $display("SCOREBOARD MISMATCH");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            $display("ran %0d commands, checked %0d words (%0d expired ids, %0d full)",
                     cmds_sent, words_seen, expired_seen, full_seen);
            if (errors == 0 && pending_words.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("%0d mismatches", errors);
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/sorted_priority_queue_unit.sv
verif/tb_sorted_priority_queue_unit.sv
